// ===== design/fps_pkg.sv =====
package fps_pkg;

  localparam int HEIGHT_WIDTH = 16;
  localparam int TIME_WIDTH   = 32;
  localparam int CFG_WIDTH    = 20;
  localparam int CFG_IDX_W    = 3;

  // phase codes
  localparam logic [2:0] PH_PRELAUNCH   = 3'd0;
  localparam logic [2:0] PH_START_DELAY = 3'd1;
  localparam logic [2:0] PH_IN_ROCKET   = 3'd2;
  localparam logic [2:0] PH_FREE_FALL   = 3'd3;
  localparam logic [2:0] PH_SPRAYING    = 3'd4;
  localparam logic [2:0] PH_GROUND      = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_DELAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRAY_WAIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRAY_DURATION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LANDING_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPRAY_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LANDING_TOL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_PERCENT  = 3'd6;

  // register reset values
  localparam logic [19:0] RST_START_DELAY    = 20'd20000;
  localparam logic [19:0] RST_SPRAY_WAIT     = 20'd5000;
  localparam logic [19:0] RST_SPRAY_DURATION = 20'd300000;
  localparam logic [19:0] RST_LANDING_WINDOW = 20'd10000;
  localparam logic [15:0] RST_SPRAY_HEIGHT   = 16'd300;
  localparam logic [15:0] RST_LANDING_TOL    = 16'd5;
  localparam logic [6:0]  RST_LIGHT_PERCENT  = 7'd90;

  localparam logic [6:0] LIGHT_SCALE = 7'd100;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]   now_ms;
    logic                    arm_lever;
    logic [15:0]             light_level;
    logic [HEIGHT_WIDTH-1:0] height_m;
  } in_t;

  typedef struct packed {
    logic [2:0] flight_phase;
    logic       spray_on;
    logic       buzzer_on;
    logic       height_settled;
  } out_t;

  typedef struct packed {
    logic [19:0] start_delay_ms;
    logic [19:0] spray_wait_ms;
    logic [19:0] spray_duration_ms;
    logic [19:0] landing_window_ms;
    logic [15:0] spray_height_limit;
    logic [15:0] landing_tolerance;
    logic [6:0]  light_percent;
  } cfg_t;

  // wrapping time difference strictly above a limit
  function automatic logic elapsed(input logic [TIME_WIDTH-1:0] now,
                                   input logic [TIME_WIDTH-1:0] start,
                                   input logic [19:0]           limit);
    logic [TIME_WIDTH-1:0] diff;
    diff = now - start;
    return diff > {{(TIME_WIDTH-20){1'b0}}, limit};
  endfunction

endpackage

// ===== design/fps_cfg_regs.sv =====
module fps_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fps_pkg::CFG_WIDTH-1:0] cfg_data,
  output fps_pkg::cfg_t                 cfg
);
  import fps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delay_ms     <= RST_START_DELAY;
      cfg.spray_wait_ms      <= RST_SPRAY_WAIT;
      cfg.spray_duration_ms  <= RST_SPRAY_DURATION;
      cfg.landing_window_ms  <= RST_LANDING_WINDOW;
      cfg.spray_height_limit <= RST_SPRAY_HEIGHT;
      cfg.landing_tolerance  <= RST_LANDING_TOL;
      cfg.light_percent      <= RST_LIGHT_PERCENT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_DELAY:    cfg.start_delay_ms     <= cfg_data;
        REG_SPRAY_WAIT:     cfg.spray_wait_ms      <= cfg_data;
        REG_SPRAY_DURATION: cfg.spray_duration_ms  <= cfg_data;
        REG_LANDING_WINDOW: cfg.landing_window_ms  <= cfg_data;
        REG_SPRAY_HEIGHT:   cfg.spray_height_limit <= cfg_data[15:0];
        REG_LANDING_TOL:    cfg.landing_tolerance  <= cfg_data[15:0];
        REG_LIGHT_PERCENT:  cfg.light_percent      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/fps_rules.sv =====
module fps_rules (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  fps_pkg::in_t  item,
  input  fps_pkg::cfg_t cfg,
  output fps_pkg::out_t res
);
  import fps_pkg::*;

  logic [2:0]              phase, phase_next;
  logic [TIME_WIDTH-1:0]   arm_time, arm_time_next;
  logic [TIME_WIDTH-1:0]   fall_start_time, fall_start_time_next;
  logic [TIME_WIDTH-1:0]   spray_start_time, spray_start_time_next;
  logic [TIME_WIDTH-1:0]   last_sample_time, last_sample_time_next;
  logic [15:0]             light_baseline, light_baseline_next;
  logic [HEIGHT_WIDTH-1:0] sample0, sample0_next;
  logic [HEIGHT_WIDTH-1:0] sample1, sample1_next;
  logic                    sample_slot, sample_slot_next;
  logic                    spray_latch, spray_latch_next;
  logic                    buzzer_latch, buzzer_latch_next;

  logic [22:0]             light_scaled, base_scaled;
  logic                    take_sample;
  logic [HEIGHT_WIDTH-1:0] gap;
  logic                    settled;

  assign light_scaled = 23'(item.light_level) * 23'(LIGHT_SCALE);
  assign base_scaled  = 23'(light_baseline) * 23'(cfg.light_percent);
  assign take_sample  = elapsed(item.now_ms, last_sample_time, cfg.landing_window_ms);

  always_comb begin
    phase_next            = phase;
    arm_time_next         = arm_time;
    fall_start_time_next  = fall_start_time;
    spray_start_time_next = spray_start_time;
    last_sample_time_next = last_sample_time;
    light_baseline_next   = light_baseline;
    sample0_next          = sample0;
    sample1_next          = sample1;
    sample_slot_next      = sample_slot;
    spray_latch_next      = spray_latch;
    buzzer_latch_next     = buzzer_latch;

    if (item.arm_lever && phase_next == PH_PRELAUNCH) begin
      phase_next          = PH_START_DELAY;
      arm_time_next       = item.now_ms;
      light_baseline_next = item.light_level;
    end
    if (phase_next == PH_START_DELAY &&
        elapsed(item.now_ms, arm_time_next, cfg.start_delay_ms)) begin
      phase_next = PH_IN_ROCKET;
    end
    // baseline is the stored one: arming and ejection never share a step
    if (phase_next == PH_IN_ROCKET && light_scaled > base_scaled) begin
      phase_next           = PH_FREE_FALL;
      fall_start_time_next = item.now_ms;
    end
    if (item.height_m < cfg.spray_height_limit && phase_next == PH_FREE_FALL &&
        elapsed(item.now_ms, fall_start_time_next, cfg.spray_wait_ms)) begin
      phase_next            = PH_SPRAYING;
      spray_latch_next      = 1'b1;
      spray_start_time_next = item.now_ms;
    end
    if (phase_next == PH_SPRAYING &&
        elapsed(item.now_ms, spray_start_time_next, cfg.spray_duration_ms)) begin
      phase_next = PH_FREE_FALL;
    end

    if (take_sample) begin
      if (sample_slot) begin
        sample1_next = item.height_m;
      end else begin
        sample0_next = item.height_m;
      end
      sample_slot_next      = ~sample_slot;
      last_sample_time_next = item.now_ms;
    end

    gap     = (sample0_next > sample1_next) ? (sample0_next - sample1_next)
                                            : (sample1_next - sample0_next);
    settled = gap < cfg.landing_tolerance;

    if (settled && phase_next == PH_FREE_FALL) begin
      phase_next        = PH_GROUND;
      buzzer_latch_next = 1'b1;
    end
  end

  assign res.flight_phase   = phase_next;
  assign res.spray_on       = spray_latch_next;
  assign res.buzzer_on      = buzzer_latch_next;
  assign res.height_settled = settled;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_PRELAUNCH;
      arm_time         <= '0;
      fall_start_time  <= '0;
      spray_start_time <= '0;
      last_sample_time <= '0;
      light_baseline   <= '0;
      sample0          <= '0;
      sample1          <= '0;
      sample_slot      <= 1'b0;
      spray_latch      <= 1'b0;
      buzzer_latch     <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      arm_time         <= arm_time_next;
      fall_start_time  <= fall_start_time_next;
      spray_start_time <= spray_start_time_next;
      last_sample_time <= last_sample_time_next;
      light_baseline   <= light_baseline_next;
      sample0          <= sample0_next;
      sample1          <= sample1_next;
      sample_slot      <= sample_slot_next;
      spray_latch      <= spray_latch_next;
      buzzer_latch     <= buzzer_latch_next;
    end
  end

`ifndef ASSERT_OFF
  a_spray_latched: assert property (@(posedge clk) disable iff (rst)
    spray_latch |=> spray_latch) else $error("spray latch dropped");
  a_buzzer_latched: assert property (@(posedge clk) disable iff (rst)
    buzzer_latch |=> buzzer_latch) else $error("buzzer latch dropped");
  a_ground_buzzer: assert property (@(posedge clk) disable iff (rst)
    phase == PH_GROUND |-> buzzer_latch) else $error("ground without buzzer");
  a_spray_phase: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SPRAYING |-> spray_latch) else $error("spraying without latch");
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase)) else $error("phase moved without a step");
`endif

endmodule

// ===== design/flight_phase_sequencer.sv =====
// path: input register, then result register; throughput: one item per cycle while
// the result side does not stall; the phase rules are one combinational pass on held state
// the next item sees the state the previous one left, updated at the same edge
// reset (rst, synchronous, active high): phase prelaunch, timers, baseline and samples zero,
// latches off, pipeline empty, registers back to their defaults
module flight_phase_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fps_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fps_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [fps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fps_pkg::CFG_WIDTH-1:0] cfg_data
);
  import fps_pkg::*;

  cfg_t cfg;
  in_t  s1_data;
  out_t res;
  logic s1_valid;
  logic adv;
  logic step;

  // result register can take a new value when empty or when its transfer happens
  assign adv      = !out_valid || !out_stall;
  // input register frees whenever its item moves on
  assign in_stall = s1_valid && !adv;
  // an item in the input register is applied to the state as it moves on
  assign step     = s1_valid && adv;

  fps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fps_rules u_rules (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (s1_data),
    .cfg  (cfg),
    .res  (res)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
    if (step) begin
      out_data <= res;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("pending result lost");
  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid) else $error("stepped item produced no result");
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall) else $error("input stalled without backpressure");
`endif

endmodule

// ===== tb/sv/flight_phase_checker.sv =====
module flight_phase_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  fps_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  fps_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [fps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fps_pkg::CFG_WIDTH-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            checked,
  output logic [5:0]                    phases_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import fps_pkg::*;

  // shadow of the register file
  logic [19:0] start_delay, spray_wait, spray_len, sample_window;
  logic [15:0] spray_ceiling, settle_tol;
  logic [6:0]  light_pct;

  // shadow of the flight state
  logic [2:0]  phase;
  logic [31:0] arm_at, fall_at, spray_at, sampled_at;
  logic [15:0] light_base;
  logic [15:0] height_pair [2];
  logic        pair_slot, spray_latched, buzzer_latched;

  out_t predicted_status [$];
  int   mismatches = 0;
  int   results_done = 0;
  logic [5:0] phase_mask = '0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 100)
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // one step of the flight rules, in their fixed order
  function automatic out_t advance_flight(input in_t it);
    out_t        res;
    logic [15:0] gap;
    logic        settled;
    if (it.arm_lever && phase == PH_PRELAUNCH) begin
      phase      = PH_START_DELAY;
      arm_at     = it.now_ms;
      light_base = it.light_level;
    end
    if (phase == PH_START_DELAY && (it.now_ms - arm_at) > 32'(start_delay))
      phase = PH_IN_ROCKET;
    if (phase == PH_IN_ROCKET &&
        32'(it.light_level) * 32'd100 > 32'(light_base) * 32'(light_pct)) begin
      phase   = PH_FREE_FALL;
      fall_at = it.now_ms;
    end
    if (it.height_m < spray_ceiling && phase == PH_FREE_FALL &&
        (it.now_ms - fall_at) > 32'(spray_wait)) begin
      phase         = PH_SPRAYING;
      spray_latched = 1'b1;
      spray_at      = it.now_ms;
    end
    if (phase == PH_SPRAYING && (it.now_ms - spray_at) > 32'(spray_len))
      phase = PH_FREE_FALL;
    // height sampling runs in every phase
    if ((it.now_ms - sampled_at) > 32'(sample_window)) begin
      height_pair[pair_slot] = it.height_m;
      pair_slot  = ~pair_slot;
      sampled_at = it.now_ms;
    end
    gap = (height_pair[0] > height_pair[1]) ? height_pair[0] - height_pair[1]
                                            : height_pair[1] - height_pair[0];
    settled = (gap < settle_tol);
    if (settled && phase == PH_FREE_FALL) begin
      phase          = PH_GROUND;
      buzzer_latched = 1'b1;
    end
    res.flight_phase   = phase;
    res.spray_on       = spray_latched;
    res.buzzer_on      = buzzer_latched;
    res.height_settled = settled;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      start_delay    = RST_START_DELAY;
      spray_wait     = RST_SPRAY_WAIT;
      spray_len      = RST_SPRAY_DURATION;
      sample_window  = RST_LANDING_WINDOW;
      spray_ceiling  = RST_SPRAY_HEIGHT;
      settle_tol     = RST_LANDING_TOL;
      light_pct      = RST_LIGHT_PERCENT;
      phase          = PH_PRELAUNCH;
      arm_at         = '0;
      fall_at        = '0;
      spray_at       = '0;
      sampled_at     = '0;
      light_base     = '0;
      height_pair[0] = '0;
      height_pair[1] = '0;
      pair_slot      = 1'b0;
      spray_latched  = 1'b0;
      buzzer_latched = 1'b0;
      predicted_status.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_done++;
        if (predicted_status.size() == 0) begin
          report_mismatch("result with no item waiting", out_data, 0);
        end else begin
          want = predicted_status.pop_front();
          if (out_data.flight_phase != want.flight_phase)
            report_mismatch("flight_phase", out_data.flight_phase, want.flight_phase);
          if (out_data.spray_on != want.spray_on)
            report_mismatch("spray_on", out_data.spray_on, want.spray_on);
          if (out_data.buzzer_on != want.buzzer_on)
            report_mismatch("buzzer_on", out_data.buzzer_on, want.buzzer_on);
          if (out_data.height_settled != want.height_settled)
            report_mismatch("height_settled", out_data.height_settled,
                            want.height_settled);
        end
      end
      if (in_valid && !in_stall) begin
        want = advance_flight(in_data);
        predicted_status.push_back(want);
        if (want.flight_phase <= PH_GROUND)
          phase_mask[want.flight_phase] = 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_START_DELAY:    start_delay   = cfg_data;
          REG_SPRAY_WAIT:     spray_wait    = cfg_data;
          REG_SPRAY_DURATION: spray_len     = cfg_data;
          REG_LANDING_WINDOW: sample_window = cfg_data;
          REG_SPRAY_HEIGHT:   spray_ceiling = cfg_data[15:0];
          REG_LANDING_TOL:    settle_tol    = cfg_data[15:0];
          REG_LIGHT_PERCENT:  light_pct     = cfg_data[6:0];
          default: ;
        endcase
      end
    end
    // exported with nonblocking updates so the stimulus side reads settled values
    fail_count  <= mismatches;
    pending     <= predicted_status.size();
    checked     <= results_done;
    phases_seen <= phase_mask;
  end

endmodule

// ===== tb/sv/tb_flight_phase_sequencer.sv =====
module tb_flight_phase_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import fps_pkg::*;

  // cycles with no transfer on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 5000;
  // index past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  // arming time chosen so the early flight wraps the millisecond counter
  localparam logic [31:0] ARM_AT = 32'hFFFF_0000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data  = '0;

  int         fail_count, pending, checked;
  logic [5:0] phases_seen;

  logic [31:0] clock_ms = '0;   // millisecond count carried from item to item
  logic [31:0] fall_ms, spray_ms;
  int          sent = 0;
  int          writes = 0;
  int          cyc = 0;
  int          idle_cycles = 0;
  logic        quiet;
  logic [19:0] reg_shadow [7];  // what was last written, used to aim time steps

  always #5 clk = ~clk;

  flight_phase_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  flight_phase_checker check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .phases_seen (phases_seen)
  );

  // a stretch of cycles where neither side idles
  assign quiet = (cyc >= 1000) && (cyc < 1600);

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // result side stalls about a third of the time outside the quiet stretch
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 33);
  end

  // watchdog: abandon the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results still due",
               idle_cycles, pending);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // time step between items: zero, one, small, near a programmed interval, or far
  function automatic logic [31:0] pick_gap();
    logic [19:0] near;
    near = reg_shadow[$urandom_range(0, 3)];
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'd1;
      2, 3:    return 32'($urandom_range(0, 64));
      4, 5:    return 32'(near) + 32'($urandom_range(0, 2)) - 32'd1;
      6:       return 32'($urandom_range(0, 2200000));
      default: return $urandom;
    endcase
  endfunction

  // one input transfer, with random idle cycles in front of it
  task automatic send_item(input in_t item);
    while (!quiet && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic push(input logic [31:0] now, input logic lever,
                      input logic [15:0] light, input logic [15:0] height);
    in_t item;
    item.now_ms      = now;
    item.arm_lever   = lever;
    item.light_level = light;
    item.height_m    = height;
    clock_ms         = now;
    send_item(item);
    sent++;
  endtask

  // drop valid and wait until every result is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx != REG_UNUSED)
      reg_shadow[idx] = value;
    writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [19:0] delay, wait_ms, spray_len, window,
                               input logic [15:0] ceiling, tol, input logic [6:0] pct);
    settle();
    cfg_write(REG_START_DELAY, delay);
    cfg_write(REG_SPRAY_WAIT, wait_ms);
    cfg_write(REG_SPRAY_DURATION, spray_len);
    cfg_write(REG_LANDING_WINDOW, window);
    cfg_write(REG_SPRAY_HEIGHT, 20'(ceiling));
    cfg_write(REG_LANDING_TOL, 20'(tol));
    cfg_write(REG_LIGHT_PERCENT, 20'(pct));
  endtask

  task automatic load_random_settings(input int tol_hi);
    load_settings(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                  16'($urandom), 16'($urandom_range(0, tol_hi)),
                  7'($urandom_range(0, 100)));
  endtask

  // random flight content; holding the height lets the samples agree
  task automatic fly(input int count, input logic hold, input logic [15:0] hold_h);
    logic [31:0] now;
    for (int i = 0; i < count; i++) begin
      now = clock_ms + pick_gap();
      push(now, 1'($urandom), 16'($urandom), hold ? hold_h : 16'($urandom));
    end
  endtask

  initial begin : stimulus
    reg_shadow = '{RST_START_DELAY, RST_SPRAY_WAIT, RST_SPRAY_DURATION,
                   RST_LANDING_WINDOW, 20'(RST_SPRAY_HEIGHT), 20'(RST_LANDING_TOL),
                   20'(RST_LIGHT_PERCENT)};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed flight on reset settings ---
    // prelaunch with the lever open: field extremes, first height sample
    push(32'd0, 1'b0, 16'd0, 16'd0);
    push(32'hFFFF_FFFF, 1'b0, 16'hFFFF, 16'hFFFF);
    // arming captures a baseline of 40000
    push(ARM_AT, 1'b1, 16'd40000, 16'd7000);
    // start delay exactly used up, not yet past
    push(ARM_AT + 32'd20000, 1'b0, 16'd0, 16'd5000);
    // in rocket; light exactly 90 percent of baseline is not ejection, lever ignored
    push(ARM_AT + 32'd20001, 1'b1, 16'd36000, 16'd100);
    // percent above 100 after masking a full-width write (127)
    settle();
    cfg_write(REG_LIGHT_PERCENT, 20'hFFFFF);
    push(ARM_AT + 32'd20002, 1'b0, 16'd50800, 16'd200);
    push(ARM_AT + 32'd20003, 1'b1, 16'd50801, 16'd250);
    fall_ms = ARM_AT + 32'd20003;
    // spray wait exactly used up, then one past with height just under the limit
    push(fall_ms + 32'd5000, 1'b0, 16'd1000, 16'd0);
    push(fall_ms + 32'd5001, 1'b1, 16'd1000, 16'd299);
    spray_ms = fall_ms + 32'd5001;
    // spray time exactly used up across the counter wrap, then spray end
    push(spray_ms + 32'd300000, 1'b0, 16'hFFFF, 16'hFFFF);
    push(spray_ms + 32'd300001, 1'b1, 16'd0, 16'd300);
    // height at the limit does not spray, one below restarts with the latch kept
    push(spray_ms + 32'd300002, 1'b0, 16'd0, 16'd300);
    push(spray_ms + 32'd300003, 1'b0, 16'd0, 16'd299);

    // --- random flight, settings changed between stretches ---
    // short timers, a sample on every advancing step, spraying toggles often
    load_settings(20'd0, 20'd0, 20'd20, 20'd0, 16'd30000, 16'd1, 7'd0);
    cfg_write(REG_UNUSED, 20'hABCDE);
    fly(300, 1'b0, 16'd0);
    // every timer and the height limit at their top value, tolerance zero never settles
    load_settings(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'd0, 7'd100);
    fly(250, 1'b0, 16'd0);
    repeat (2) begin
      load_random_settings(2);
      fly(200, 1'b0, 16'd0);
    end
    // spraying never starts, any spray in progress ends once time advances
    load_settings(20'd1, 20'd0, 20'd0, 20'd3, 16'd0, 16'd2, 7'd90);
    fly(150, 1'b0, 16'd0);

    // --- landing ---
    load_settings(20'd0, 20'd0, 20'd0, 20'd0, 16'd0, 16'd10, 7'd50);
    // samples exactly the tolerance apart are not settled
    push(clock_ms + 32'd1, 1'b0, 16'd500, 16'd1000);
    push(clock_ms + 32'd1, 1'b0, 16'd500, 16'd1010);
    fly(20, 1'b1, 16'd1234);

    // --- on the ground: sampling and the settled flag keep running ---
    load_settings(20'($urandom), 20'd0, 20'($urandom), 20'd0, 16'($urandom),
                  16'hFFFF, 7'd0);
    // full-range gap is not below the widest tolerance
    push(clock_ms + 32'd1, 1'b0, 16'd0, 16'd0);
    push(clock_ms + 32'd1, 1'b1, 16'hFFFF, 16'hFFFF);
    fly(110, 1'b0, 16'd0);
    load_settings(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom_range(0, 40)),
                  16'($urandom), 16'($urandom_range(0, 40000)), 7'($urandom_range(0, 100)));
    fly(110, 1'b0, 16'd0);

    settle();
    $display("flight run: %0d input transfers, %0d results checked, %0d register writes",
             sent, checked, writes);
    $display("phases reached, one bit per phase from prelaunch up: %b", phases_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
